/* sv/arpc_pkg.sv */
// shared constants, types and helpers for the arp cache
`default_nettype none
package arpc_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W    = 4;
    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int TICK_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP  = 2'd2;

    localparam logic FUNC_RESOLVE = 1'b0;
    localparam logic FUNC_LEARN   = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } arpc_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } arpc_sts_t;

    function automatic logic [SLOT_W-1:0] idx_to_slot(input idx_t idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* sv/arpc_ctrl.sv */
// controller state machine: accept, scan, drain, write back
`default_nettype none
module arpc_ctrl
    import arpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire arpc_sts_t sts,
    output arpc_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd.start  = (state_reg == ST_IDLE) && in_valid;
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.finish = (state_reg == ST_WRITE) && sts.out_free;
        in_stall   = (state_reg != ST_IDLE);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == ST_SCAN)
        else $error("request accepted but scan did not begin");
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && sts.scan_last |=> state_reg == ST_DRAIN)
        else $error("scan did not stop after the last entry");
`endif

endmodule
`default_nettype wire

/* sv/arpc_dp.sv */
// datapath: config registers, entry memories, scan search and result register
`default_nettype none
module arpc_dp
    import arpc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 func,
    input  wire logic [IP_W-1:0]      ip_addr,
    input  wire logic [MAC_W-1:0]     mac_in,
    input  wire logic [TICK_W-1:0]    now_tick,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      hit,
    output logic [MAC_W-1:0]          mac_out,
    output logic [SLOT_W-1:0]         slot,
    output logic                      evicted,
    output logic [IP_W-1:0]           next_hop_ip,
    input  wire arpc_cmd_t            cmd,
    output arpc_sts_t                 sts
);

    logic [IP_W-1:0] local_ip_reg;
    logic [IP_W-1:0] subnet_mask_reg;
    logic [IP_W-1:0] gateway_ip_reg;

    logic [IP_W-1:0]   ip_mem    [ENTRIES];
    logic [MAC_W-1:0]  mac_mem   [ENTRIES];
    logic [TICK_W-1:0] stamp_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    // request registers
    logic              func_reg;
    logic [IP_W-1:0]   key_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [TICK_W-1:0] tick_reg;

    // scan pipeline
    idx_t              addr_reg;
    logic              rd_valid_reg;
    idx_t              rd_idx_reg;
    logic              rd_v_reg;
    logic [IP_W-1:0]   rd_ip_reg;
    logic [MAC_W-1:0]  rd_mac_reg;
    logic [TICK_W-1:0] rd_stamp_reg;

    // search results
    logic              found_reg;
    idx_t              found_idx_reg;
    logic [MAC_W-1:0]  found_mac_reg;
    logic              free_found_reg;
    idx_t              free_idx_reg;
    logic [TICK_W-1:0] min_stamp_reg;
    idx_t              min_idx_reg;

    logic                out_valid_reg;
    logic                hit_reg;
    logic [MAC_W-1:0]    mac_out_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                evicted_reg;
    logic [IP_W-1:0]     next_hop_reg;

    logic            off_subnet;
    logic [IP_W-1:0] hop;
    logic            learn;
    idx_t            wr_idx;
    logic            new_entry;
    logic            do_evict;

    assign off_subnet = ((ip_addr ^ local_ip_reg) & subnet_mask_reg) != '0;
    assign hop = (func == FUNC_RESOLVE && off_subnet) ? gateway_ip_reg : ip_addr;

    assign learn     = (func_reg == FUNC_LEARN);
    assign new_entry = learn && !found_reg;
    assign do_evict  = new_entry && !free_found_reg;
    assign wr_idx    = found_reg ? found_idx_reg :
                       (free_found_reg ? free_idx_reg : min_idx_reg);

    assign sts.scan_last = (addr_reg == idx_t'(ENTRIES - 1));
    assign sts.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg    <= '0;
            subnet_mask_reg <= '0;
            gateway_ip_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOCAL_IP:    local_ip_reg    <= cfg_data;
                CFG_SUBNET_MASK: subnet_mask_reg <= cfg_data;
                CFG_GATEWAY_IP:  gateway_ip_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // entry memories: one read port for the scan, one write port
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            rd_ip_reg    <= ip_mem[addr_reg];
            rd_mac_reg   <= mac_mem[addr_reg];
            rd_stamp_reg <= stamp_mem[addr_reg];
        end
        if (cmd.finish && learn)
        begin
            mac_mem[wr_idx]   <= mac_reg;
            stamp_mem[wr_idx] <= tick_reg;
            if (new_entry)
                ip_mem[wr_idx] <= key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            addr_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan;
            if (cmd.start)
            begin
                addr_reg       <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan)
                    addr_reg <= addr_reg + 1'b1;
                if (rd_valid_reg && !found_reg && rd_v_reg && rd_ip_reg == key_reg)
                    found_reg <= 1'b1;
                if (rd_valid_reg && !free_found_reg && !rd_v_reg)
                    free_found_reg <= 1'b1;
            end
            if (cmd.finish && learn)
                valid_reg[wr_idx] <= 1'b1;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg <= func;
            key_reg  <= hop;
            mac_reg  <= mac_in;
            tick_reg <= now_tick;
        end
        if (cmd.scan)
        begin
            rd_idx_reg <= addr_reg;
            rd_v_reg   <= valid_reg[addr_reg];
        end
        if (rd_valid_reg)
        begin
            if (!found_reg && rd_v_reg && rd_ip_reg == key_reg)
            begin
                found_idx_reg <= rd_idx_reg;
                found_mac_reg <= rd_mac_reg;
            end
            if (!free_found_reg && !rd_v_reg)
                free_idx_reg <= rd_idx_reg;
            // strict less keeps the lowest index on equal stamps
            if (rd_idx_reg == '0 || rd_stamp_reg < min_stamp_reg)
            begin
                min_stamp_reg <= rd_stamp_reg;
                min_idx_reg   <= rd_idx_reg;
            end
        end
        if (cmd.finish)
        begin
            hit_reg      <= found_reg;
            mac_out_reg  <= (!learn && found_reg) ? found_mac_reg : '0;
            slot_reg     <= learn ? idx_to_slot(wr_idx) :
                            (found_reg ? idx_to_slot(found_idx_reg) : '0);
            evicted_reg  <= do_evict;
            next_hop_reg <= key_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign mac_out     = mac_out_reg;
    assign slot        = slot_reg;
    assign evicted     = evicted_reg;
    assign next_hop_ip = next_hop_reg;

`ifndef ASSERT_OFF
    a_found_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> valid_reg[found_idx_reg])
        else $error("match points at an entry that is not valid");
    a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && do_evict |-> &valid_reg)
        else $error("replacement while a free entry exists");
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result appeared without a finished request");
`endif

endmodule
`default_nettype wire

/* sv/arp_cache_oldest_replace.sv */
// arp cache top level with oldest-entry replacement
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  func, ip_addr, mac_in, now_tick
//  out      output     out_valid/out_stall  hit, mac_out, slot, evicted, next_hop_ip
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// one request passes through accept, a scan of each entry
// through the single read port of the entry memories, a drain and a write back
// the next request is taken once the write back has loaded the result register
// reset clears config registers and all entry valid bits at once; no clearing pass
// a stalled result holds the write back until the result register frees up
`default_nettype none
module arp_cache_oldest_replace
    import arpc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 func,
    input  wire logic [IP_W-1:0]      ip_addr,
    input  wire logic [MAC_W-1:0]     mac_in,
    input  wire logic [TICK_W-1:0]    now_tick,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      hit,
    output logic [MAC_W-1:0]          mac_out,
    output logic [SLOT_W-1:0]         slot,
    output logic                      evicted,
    output logic [IP_W-1:0]           next_hop_ip
);

    arpc_cmd_t cmd;
    arpc_sts_t sts;

    arpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    arpc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .ip_addr     (ip_addr),
        .mac_in      (mac_in),
        .now_tick    (now_tick),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .mac_out     (mac_out),
        .slot        (slot),
        .evicted     (evicted),
        .next_hop_ip (next_hop_ip),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
`default_nettype wire

/* dv/arp_cache_oldest_replace_tb.sv */
// testbench for the arp cache with oldest-entry replacement
`timescale 1ns / 1ps
module arp_cache_oldest_replace_tb;
    import arpc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int POOL_SIZE      = 22;
    localparam int PHASE_REQS     = 400;
    localparam int DRAIN_CYCLES   = 32;
    localparam int HOLD_AT        = 600;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 25;

    typedef struct packed {
        logic              fn;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TICK_W-1:0] tick;
    } arp_req_t;

    typedef struct packed {
        logic              hit;
        logic [MAC_W-1:0]  mac;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [IP_W-1:0]   hop;
    } arp_rsp_t;

    typedef struct packed {
        arp_req_t req;
        logic     known;
        arp_rsp_t rsp;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 func;
    logic [IP_W-1:0]      ip_addr;
    logic [MAC_W-1:0]     mac_in;
    logic [TICK_W-1:0]    now_tick;
    logic                 out_valid;
    logic                 out_stall;
    logic                 hit;
    logic [MAC_W-1:0]     mac_out;
    logic [SLOT_W-1:0]    slot;
    logic                 evicted;
    logic [IP_W-1:0]      next_hop_ip;

    // shadow copy of the cache and its registers
    logic [IP_W-1:0]   own_ip;
    logic [IP_W-1:0]   net_mask;
    logic [IP_W-1:0]   gw_ip;
    logic              tbl_valid [ENTRIES];
    logic [IP_W-1:0]   tbl_ip    [ENTRIES];
    logic [MAC_W-1:0]  tbl_mac   [ENTRIES];
    logic [TICK_W-1:0] tbl_stamp [ENTRIES];

    arp_rsp_t          pending_replies [$];
    logic [IP_W-1:0]   ip_pool [POOL_SIZE];
    logic [TICK_W-1:0] tick_clock;
    int                error_count;
    int                reqs_sent;
    int                replies_seen;
    int                idle_cycles;

    // reset config: mask 0 keeps every destination on the subnet
    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{FUNC_RESOLVE, 32'h0000_0000, 48'h0, 32'h0}, 1'b1,
          '{1'b0, 48'h0, 4'd0, 1'b0, 32'h0000_0000}},
        '{'{FUNC_RESOLVE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0}, 1'b1,
          '{1'b0, 48'h0, 4'd0, 1'b0, 32'hFFFF_FFFF}},
        '{'{FUNC_LEARN, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 32'h0}, 1'b1,
          '{1'b0, 48'h0, 4'd0, 1'b0, 32'h0A00_0001}},
        '{'{FUNC_LEARN, 32'hFFFF_FFFF, 48'h0, 32'hFFFF_FFFF}, 1'b1,
          '{1'b0, 48'h0, 4'd1, 1'b0, 32'hFFFF_FFFF}},
        '{'{FUNC_RESOLVE, 32'h0A00_0001, 48'h0, 32'h0}, 1'b1,
          '{1'b1, 48'hFFFF_FFFF_FFFF, 4'd0, 1'b0, 32'h0A00_0001}},
        '{'{FUNC_RESOLVE, 32'hFFFF_FFFF, 48'h0, 32'h0}, 1'b1,
          '{1'b1, 48'h0, 4'd1, 1'b0, 32'hFFFF_FFFF}},
        // refresh of an existing entry
        '{'{FUNC_LEARN, 32'h0A00_0001, 48'h1234_5678_9ABC, 32'd5}, 1'b1,
          '{1'b1, 48'h0, 4'd0, 1'b0, 32'h0A00_0001}},
        '{'{FUNC_RESOLVE, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{1'b1, 48'h1234_5678_9ABC, 4'd0, 1'b0, 32'h0A00_0001}},
        // fill the remaining slots
        '{'{FUNC_LEARN, 32'hC0A8_0002, 48'h5555_5555_5502, 32'h102}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_0003, 48'h5555_5555_5503, 32'h103}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_0004, 48'h5555_5555_5504, 32'h104}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_0005, 48'h5555_5555_5505, 32'h105}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_0006, 48'h5555_5555_5506, 32'h106}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_0007, 48'h5555_5555_5507, 32'h107}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_0008, 48'h5555_5555_5508, 32'h108}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_0009, 48'h5555_5555_5509, 32'h109}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_000A, 48'h5555_5555_550A, 32'h10A}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_000B, 48'h5555_5555_550B, 32'h10B}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_000C, 48'h5555_5555_550C, 32'h10C}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_000D, 48'h5555_5555_550D, 32'h10D}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_000E, 48'h5555_5555_550E, 32'h10E}, 1'b0, '0},
        '{'{FUNC_LEARN, 32'hC0A8_000F, 48'h5555_5555_550F, 32'h10F}, 1'b0, '0},
        // full table: slot 0 holds the smallest stamp
        '{'{FUNC_LEARN, 32'h0A0A_0A0A, 48'hAAAA_AAAA_AAAA, 32'd7}, 1'b1,
          '{1'b0, 48'h0, 4'd0, 1'b1, 32'h0A0A_0A0A}},
        '{'{FUNC_RESOLVE, 32'h0A00_0001, 48'h0, 32'h0}, 1'b1,
          '{1'b0, 48'h0, 4'd0, 1'b0, 32'h0A00_0001}},
        '{'{FUNC_RESOLVE, 32'h0A0A_0A0A, 48'h0, 32'h0}, 1'b1,
          '{1'b1, 48'hAAAA_AAAA_AAAA, 4'd0, 1'b0, 32'h0A0A_0A0A}}
    };

    arp_cache_oldest_replace u_dut (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int match_index(input logic [IP_W-1:0] ip);
        int i;
        for (i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // expected reply for one request; learns also update the shadow table
    function automatic arp_rsp_t cache_lookup(input arp_req_t r);
        arp_rsp_t o;
        int       k;
        int       i;
        o = '0;
        o.hop = r.ip;
        if (r.fn == FUNC_RESOLVE)
        begin
            if ((r.ip & net_mask) != (own_ip & net_mask))
                o.hop = gw_ip;
            k = match_index(o.hop);
            if (k >= 0)
            begin
                o.hit  = 1'b1;
                o.mac  = tbl_mac[k];
                o.slot = SLOT_W'(k);
            end
        end
        else
        begin
            k = match_index(r.ip);
            if (k >= 0)
                o.hit = 1'b1;
            else
            begin
                for (i = 0; i < ENTRIES; i++)
                    if (!tbl_valid[i] && k < 0)
                        k = i;
                if (k < 0)
                begin
                    // strict compare keeps the lowest index on equal stamps
                    k = 0;
                    for (i = 1; i < ENTRIES; i++)
                        if (tbl_stamp[i] < tbl_stamp[k])
                            k = i;
                    o.evicted = 1'b1;
                end
                tbl_ip[k]    = r.ip;
                tbl_valid[k] = 1'b1;
            end
            tbl_mac[k]   = r.mac;
            tbl_stamp[k] = r.tick;
            o.slot       = SLOT_W'(k);
        end
        return o;
    endfunction

    task automatic send_request(input arp_req_t r, input logic known, input arp_rsp_t typed);
        int       gap;
        arp_rsp_t predicted;
        gap = ((reqs_sent % 128) < 24) ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= r.fn;
        ip_addr  <= r.ip;
        mac_in   <= r.mac;
        now_tick <= r.tick;
        do
            @(posedge clk);
        while (in_stall);
        predicted = cache_lookup(r);
        pending_replies.push_back(known ? typed : predicted);
        reqs_sent++;
    endtask

    task automatic drain_requests();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LOCAL_IP:    own_ip   = val;
            CFG_SUBNET_MASK: net_mask = val;
            CFG_GATEWAY_IP:  gw_ip    = val;
            default: ;
        endcase
    endtask

    // pool larger than the table so learns refresh, fill and evict
    task automatic build_pool();
        int i;
        for (i = 0; i < 8; i++)
            ip_pool[i] = (own_ip & net_mask) | ($urandom & ~net_mask);
        for (i = 8; i < POOL_SIZE - 2; i++)
            ip_pool[i] = $urandom;
        ip_pool[POOL_SIZE-2] = gw_ip;
        ip_pool[POOL_SIZE-1] = own_ip;
    endtask

    task automatic run_random(input int count);
        arp_req_t r;
        int       n;
        build_pool();
        for (n = 0; n < count; n++)
        begin
            r.fn  = 1'($urandom_range(0, 1));
            r.ip  = ($urandom_range(0, 9) == 0) ? $urandom
                                                : ip_pool[$urandom_range(0, POOL_SIZE-1)];
            r.mac = MAC_W'({$urandom, $urandom});
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    tick_clock = tick_clock + $urandom_range(0, 4);
                    r.tick = tick_clock;
                end
                // tiny range forces equal stamps
                2: r.tick = $urandom_range(0, 3);
                default: r.tick = $urandom;
            endcase
            send_request(r, 1'b0, '0);
        end
    endtask

    task automatic check_reply();
        arp_rsp_t e;
        if (pending_replies.size() == 0)
        begin
            $error("reply with no pending request: slot %0d hop %h", slot, next_hop_ip);
            error_count++;
        end
        else
        begin
            e = pending_replies.pop_front();
            if (hit !== e.hit)
            begin
                $error("hit: expected %0d, got %0d", e.hit, hit);
                error_count++;
            end
            if (mac_out !== e.mac)
            begin
                $error("mac_out: expected %h, got %h", e.mac, mac_out);
                error_count++;
            end
            if (slot !== e.slot)
            begin
                $error("slot: expected %0d, got %0d", e.slot, slot);
                error_count++;
            end
            if (evicted !== e.evicted)
            begin
                $error("evicted: expected %0d, got %0d", e.evicted, evicted);
                error_count++;
            end
            if (next_hop_ip !== e.hop)
            begin
                $error("next_hop_ip: expected %h, got %h", e.hop, next_hop_ip);
                error_count++;
            end
        end
    endtask

    // result side: random stall per reply, one long hold to back up the input
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        replies_seen = 0;
        out_stall    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                if (out_valid)
                    stall_left--;
            end
            else
                out_stall <= 1'b0;
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                check_reply();
                replies_seen++;
                stall_left = ((replies_seen % 128) < 24) ? 0 : $urandom_range(0, 8);
                if (replies_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("arp_cache_oldest_replace verification failed");
        $finish;
    end

    initial
    begin
        int i;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        func        = FUNC_RESOLVE;
        ip_addr     = '0;
        mac_in      = '0;
        now_tick    = '0;
        own_ip      = '0;
        net_mask    = '0;
        gw_ip       = '0;
        tick_clock  = '0;
        error_count = 0;
        reqs_sent   = 0;
        for (i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i]    = '0;
            tbl_mac[i]   = '0;
            tbl_stamp[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_request(directed_rows[i].req, directed_rows[i].known,
                         directed_rows[i].rsp);
        drain_requests();

        // class c subnet; the unused register index must be ignored
        write_reg(CFG_LOCAL_IP, 32'hC0A8_0001);
        write_reg(CFG_SUBNET_MASK, 32'hFFFF_FF00);
        write_reg(CFG_GATEWAY_IP, 32'hC0A8_00FE);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        run_random(PHASE_REQS);
        drain_requests();

        // host mask: only the own address stays local
        write_reg(CFG_SUBNET_MASK, 32'hFFFF_FFFF);
        write_reg(CFG_LOCAL_IP, $urandom);
        write_reg(CFG_GATEWAY_IP, 32'hFFFF_FFFF);
        run_random(PHASE_REQS);
        drain_requests();

        // empty mask: everything is local
        write_reg(CFG_SUBNET_MASK, 32'h0000_0000);
        write_reg(CFG_LOCAL_IP, 32'hFFFF_FFFF);
        write_reg(CFG_GATEWAY_IP, 32'h0000_0000);
        run_random(PHASE_REQS);
        drain_requests();

        write_reg(CFG_LOCAL_IP, $urandom);
        write_reg(CFG_SUBNET_MASK, 32'hFFFF_FFFF << $urandom_range(1, 31));
        write_reg(CFG_GATEWAY_IP, $urandom);
        run_random(PHASE_REQS);
        drain_requests();

        if (error_count == 0 && pending_replies.size() == 0)
            $display("arp_cache_oldest_replace verification clean");
        else
            $display("arp_cache_oldest_replace verification failed");
        $finish;
    end

endmodule
